>>> rtl/core/alp_ds_pkg.sv
// Shared types and constants of the decimal scale encoder.
package alp_ds_pkg;

   localparam int MANT_W = 53;
   localparam int EXP_W = 13;
   localparam int PROD_W = 2 * MANT_W;
   localparam int CNT_W = 6;
   localparam int ENC_W = 55;
   localparam int MAG_W = 54;
   localparam int POS_W = 16;
   localparam int EXC_CNT_W = 17;
   localparam int RSP_DATA_W = 280;
   localparam int MAX_BLOCK_ITEMS_DEF = 65536;

   localparam logic [63:0] FACTOR_RESET = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
   localparam logic [MANT_W-1:0] MANT_ONE = {1'b1, {(MANT_W-1){1'b0}}};
   localparam logic [MAG_W-1:0] MAG_TWO_53 = {1'b1, {(MAG_W-1){1'b0}}};

   typedef logic signed [EXP_W-1:0] exp_type;
   typedef logic [MANT_W-1:0] mant_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_MUL,
      ST_MRND,
      ST_SHIFT,
      ST_NORM2,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_ITER,
      DV_PAD
   } div_state_type;

   typedef struct packed {
      logic start;
      logic pre_shift;
      logic [CNT_W-1:0] keep;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic carry;
   } div_rsp_type;

   typedef struct packed {
      logic valid;
      logic exact;
      logic signed [ENC_W-1:0] encoded;
      logic [63:0] raw_bits;
      logic last;
   } item_type;

endpackage

>>> rtl/core/alp_ds_mul.sv
// Bit-serial shift-and-add multiplier for 53-bit significands.
module alp_ds_mul (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [alp_ds_pkg::MANT_W-1:0] a,
   input  logic [alp_ds_pkg::MANT_W-1:0] b,
   output logic done,
   output logic [alp_ds_pkg::PROD_W-1:0] product
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [alp_ds_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [alp_ds_pkg::MANT_W-1:0] hi_ff, hi_in;
   logic [alp_ds_pkg::MANT_W-1:0] lo_ff, lo_in;
   logic [alp_ds_pkg::MANT_W-1:0] addend;
   logic [alp_ds_pkg::MANT_W:0] sum;

   always_comb begin
      addend = lo_ff[0] ? a : '0;
      sum = {1'b0, hi_ff} + {1'b0, addend};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = alp_ds_pkg::CNT_W'(alp_ds_pkg::MANT_W);
         hi_in = '0;
         lo_in = b;
      end else if (busy_ff) begin
         hi_in = sum[alp_ds_pkg::MANT_W:1];
         lo_in = {sum[0], lo_ff[alp_ds_pkg::MANT_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == alp_ds_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

>>> rtl/core/alp_ds_div.sv
// Restoring bit-serial divider with round to nearest even at a chosen width.
module alp_ds_div (
   input  logic clock,
   input  logic reset,
   input  alp_ds_pkg::div_cmd_type cmd,
   input  logic [alp_ds_pkg::MANT_W-1:0] n,
   input  logic [alp_ds_pkg::MANT_W-1:0] d,
   output alp_ds_pkg::div_rsp_type rsp,
   output logic [alp_ds_pkg::MANT_W-1:0] quot
);

   alp_ds_pkg::div_state_type state_ff, state_in;
   logic done_ff, done_in;
   logic [alp_ds_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [alp_ds_pkg::CNT_W-1:0] pad_ff, pad_in;
   logic [alp_ds_pkg::MAG_W-1:0] rem_ff, rem_in;
   logic [alp_ds_pkg::MAG_W-1:0] q_ff, q_in;
   logic [alp_ds_pkg::MAG_W:0] diff;
   logic ge;
   logic [alp_ds_pkg::MAG_W-1:0] rem_sub;
   logic inc;

   always_comb begin
      diff = {1'b0, rem_ff} - {2'b00, d};
      ge = !diff[alp_ds_pkg::MAG_W];
      rem_sub = ge ? diff[alp_ds_pkg::MAG_W-1:0] : rem_ff;
      inc = ge & ((rem_sub != '0) | q_ff[0]);
      state_in = state_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      pad_in = pad_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      unique case (state_ff)
         alp_ds_pkg::DV_IDLE: begin
            if (cmd.start) begin
               rem_in = cmd.pre_shift ? {n, 1'b0} : {1'b0, n};
               q_in = '0;
               cnt_in = cmd.keep;
               pad_in = alp_ds_pkg::CNT_W'(alp_ds_pkg::MANT_W) - cmd.keep;
               state_in = alp_ds_pkg::DV_ITER;
            end
         end
         alp_ds_pkg::DV_ITER: begin
            rem_in = {rem_sub[alp_ds_pkg::MAG_W-2:0], 1'b0};
            if (cnt_ff != '0) begin
               q_in = {q_ff[alp_ds_pkg::MAG_W-2:0], ge};
               cnt_in = cnt_ff - 1'b1;
            end else begin
               q_in = q_ff + alp_ds_pkg::MAG_W'(inc);
               if (pad_ff == '0) begin
                  done_in = 1'b1;
                  state_in = alp_ds_pkg::DV_IDLE;
               end else begin
                  state_in = alp_ds_pkg::DV_PAD;
               end
            end
         end
         alp_ds_pkg::DV_PAD: begin
            q_in = {q_ff[alp_ds_pkg::MAG_W-2:0], 1'b0};
            pad_in = pad_ff - 1'b1;
            if (pad_ff == alp_ds_pkg::CNT_W'(1)) begin
               done_in = 1'b1;
               state_in = alp_ds_pkg::DV_IDLE;
            end
         end
         default: state_in = alp_ds_pkg::DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alp_ds_pkg::DV_IDLE;
         done_ff <= 1'b0;
         cnt_ff <= '0;
         pad_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
         pad_ff <= pad_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
   end

   assign rsp.done = done_ff;
   assign rsp.carry = q_ff[alp_ds_pkg::MAG_W-1];
   assign quot = q_ff[alp_ds_pkg::MAG_W-1] ? alp_ds_pkg::MANT_ONE
                                           : q_ff[alp_ds_pkg::MANT_W-1:0];

endmodule

>>> rtl/core/alp_ds_acc.sv
// Block totals, position counter and result register.
module alp_ds_acc #(
   parameter int MAX_BLOCK_ITEMS = alp_ds_pkg::MAX_BLOCK_ITEMS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  alp_ds_pkg::item_type item,
   output logic ready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [alp_ds_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic rsp_tuser,
   output logic rsp_tlast
);

   localparam logic [alp_ds_pkg::POS_W-1:0] LAST_POS =
      alp_ds_pkg::POS_W'(MAX_BLOCK_ITEMS - 1);
   localparam logic signed [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] INT64_MIN = {1'b1, {63{1'b0}}};

   logic [alp_ds_pkg::POS_W-1:0] idx_ff, idx_in;
   logic signed [63:0] min_ff, min_in;
   logic signed [63:0] max_ff, max_in;
   logic [alp_ds_pkg::EXC_CNT_W-1:0] exc_ff, exc_in;
   logic valid_ff, valid_in;
   logic [alp_ds_pkg::RSP_DATA_W-1:0] data_ff, data_in;
   logic user_ff, user_in;
   logic last_ff, last_in;
   logic commit;
   logic block_end;
   logic signed [63:0] e64;
   logic signed [63:0] new_min;
   logic signed [63:0] new_max;
   logic [alp_ds_pkg::EXC_CNT_W-1:0] new_exc;
   logic [63:0] exc_bits;

   assign ready = !valid_ff || rsp_tready;
   assign commit = item.valid && ready;

   always_comb begin
      e64 = {{(64 - alp_ds_pkg::ENC_W){item.encoded[alp_ds_pkg::ENC_W-1]}}, item.encoded};
      new_min = (item.exact && (e64 < min_ff)) ? e64 : min_ff;
      new_max = (item.exact && (e64 > max_ff)) ? e64 : max_ff;
      new_exc = exc_ff + alp_ds_pkg::EXC_CNT_W'(!item.exact);
      exc_bits = item.exact ? '0 : item.raw_bits;
      block_end = item.last || (idx_ff == LAST_POS);
      idx_in = idx_ff;
      min_in = min_ff;
      max_in = max_ff;
      exc_in = exc_ff;
      valid_in = valid_ff;
      data_in = data_ff;
      user_in = user_ff;
      last_in = last_ff;
      if (commit) begin
         valid_in = 1'b1;
         data_in = {new_exc, new_max, new_min, exc_bits, idx_ff, item.encoded};
         user_in = !item.exact;
         last_in = block_end;
         if (block_end) begin
            idx_in = '0;
            min_in = INT64_MAX;
            max_in = INT64_MIN;
            exc_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
            min_in = new_min;
            max_in = new_max;
            exc_in = new_exc;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         min_ff <= INT64_MAX;
         max_ff <= INT64_MIN;
         exc_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         min_ff <= min_in;
         max_ff <= max_in;
         exc_ff <= exc_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;
   assign rsp_tlast = last_ff;

endmodule

>>> rtl/core/alp_decimal_scale_encoder.sv
// Top level of the decimal scale encoder: sequencer, rounding and config register.
//
// Input channel req_*: one IEEE double per beat in req_tdata, req_tlast ends a block.
// Result channel rsp_*: one beat per input beat, in order, tlast on the block's end.
// csr_wr_en / csr_wr_data write the double bit pattern of the scale factor.
// Each value is scaled, rounded half away from zero and checked by dividing back.
// An item is taken only while the sequencer is idle. Subnormal operands are
// first normalized; the serial multiplier forms the product, which is rounded
// to 53 bits, then the fraction dropped by rounding is shifted out, the integer
// is renormalized and the serial divider divides it back. NaN, infinity, zero
// and negative zero values and zero, infinite or NaN factors go straight from
// idle to the done state; scaled magnitudes above 2^53 or below one half skip
// the shift and the divider.
// The result sits in an output register: the next item is accepted while it
// waits, in the cycle after the result enters the register, and the sequencer
// holds its finished item until the register frees.
// Reset clears the block totals, empties the output register and sets the
// factor to 1.0.
module alp_decimal_scale_encoder #(
   parameter int MAX_BLOCK_ITEMS = alp_ds_pkg::MAX_BLOCK_ITEMS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [63:0] req_tdata,   // value_bits[63:0]
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // encoded[54:0], position[70:55], exception_bits[134:71], running_min[198:135],
   // running_max[262:199], exception_count[279:263]
   output logic [alp_ds_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic rsp_tuser,          // is_exception[0]
   output logic rsp_tlast,
   input  logic csr_wr_en,
   input  logic [63:0] csr_wr_data
);

   localparam int MW = alp_ds_pkg::MANT_W;

   alp_ds_pkg::state_type state_ff, state_in;
   logic [63:0] factor_ff;
   logic [63:0] vbits_ff, vbits_in;
   logic last_ff, last_in;
   logic sign_ff, sign_in;
   logic exact_ff, exact_in;
   alp_ds_pkg::mant_type mv_ff, mv_in;
   alp_ds_pkg::mant_type mf_ff, mf_in;
   alp_ds_pkg::exp_type ev_ff, ev_in;
   alp_ds_pkg::exp_type ef_ff, ef_in;
   alp_ds_pkg::mant_type sh_ff, sh_in;
   logic [alp_ds_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [alp_ds_pkg::MAG_W-1:0] mag_ff, mag_in;
   alp_ds_pkg::mant_type nrm_ff, nrm_in;
   alp_ds_pkg::exp_type en_ff, en_in;
   alp_ds_pkg::exp_type l_ff, l_in;

   logic [10:0] v_exp, f_exp;
   logic pre_ok, v_zero;
   alp_ds_pkg::mant_type v_mant, f_mant;
   alp_ds_pkg::exp_type v_e, f_e;

   logic mul_start, mul_done;
   logic [alp_ds_pkg::PROD_W-1:0] product;
   logic p_top, g_bit, st_bit, r_inc;
   alp_ds_pkg::mant_type p_mant, mp;
   logic [MW:0] p_sum;
   alp_ds_pkg::exp_type ep, neg_ep;
   logic [alp_ds_pkg::MAG_W-1:0] shift_mag;

   logic n_ge_d;
   alp_ds_pkg::exp_type lead;
   logic signed [alp_ds_pkg::EXP_W:0] shrink;
   logic [alp_ds_pkg::CNT_W-1:0] keep;
   alp_ds_pkg::div_cmd_type div_cmd;
   alp_ds_pkg::div_rsp_type div_rsp;
   alp_ds_pkg::mant_type quot;
   alp_ds_pkg::exp_type ed;

   logic acc_ready;
   alp_ds_pkg::item_type item;
   logic [alp_ds_pkg::MAG_W:0] mag_ext;

   always_comb begin
      v_exp = req_tdata[62:52];
      f_exp = factor_ff[62:52];
      v_mant = {v_exp != '0, req_tdata[51:0]};
      f_mant = {f_exp != '0, factor_ff[51:0]};
      v_e = alp_ds_pkg::exp_type'({2'b00, (v_exp == '0) ? 11'd1 : v_exp})
            - alp_ds_pkg::exp_type'(1075);
      f_e = alp_ds_pkg::exp_type'({2'b00, (f_exp == '0) ? 11'd1 : f_exp})
            - alp_ds_pkg::exp_type'(1075);
      pre_ok = (req_tdata != alp_ds_pkg::NEG_ZERO) && (v_exp != alp_ds_pkg::EXP_ALL_ONES)
               && (f_exp != alp_ds_pkg::EXP_ALL_ONES) && (factor_ff[62:0] != '0);
      v_zero = (req_tdata[62:0] == '0);
   end

   always_comb begin
      p_top = product[alp_ds_pkg::PROD_W-1];
      p_mant = p_top ? product[alp_ds_pkg::PROD_W-1:MW] : product[alp_ds_pkg::PROD_W-2:MW-1];
      g_bit = p_top ? product[MW-1] : product[MW-2];
      st_bit = p_top ? (product[MW-2:0] != '0) : (product[MW-3:0] != '0);
      r_inc = g_bit & (st_bit | p_mant[0]);
      p_sum = {1'b0, p_mant} + (MW+1)'(r_inc);
      mp = p_sum[MW] ? alp_ds_pkg::MANT_ONE : p_sum[MW-1:0];
      ep = ev_ff + ef_ff + (p_top ? alp_ds_pkg::exp_type'(53) : alp_ds_pkg::exp_type'(52))
           + alp_ds_pkg::exp_type'({1'b0, p_sum[MW]});
      neg_ep = -ep;
      shift_mag = {2'b00, sh_ff[MW-1:1]} + alp_ds_pkg::MAG_W'(sh_ff[0]);
   end

   always_comb begin
      n_ge_d = (nrm_ff >= mf_ff);
      lead = en_ff - ef_ff - (n_ge_d ? alp_ds_pkg::exp_type'(0) : alp_ds_pkg::exp_type'(1));
      shrink = -(alp_ds_pkg::EXP_W+1)'(1022) - (alp_ds_pkg::EXP_W+1)'(lead);
      if (shrink <= 0) begin
         keep = alp_ds_pkg::CNT_W'(MW);
      end else if (shrink >= (alp_ds_pkg::EXP_W+1)'(MW)) begin
         keep = alp_ds_pkg::CNT_W'(1);
      end else begin
         keep = alp_ds_pkg::CNT_W'(MW) - shrink[alp_ds_pkg::CNT_W-1:0];
      end
      ed = l_ff - alp_ds_pkg::exp_type'(52) + alp_ds_pkg::exp_type'({1'b0, div_rsp.carry});
      mag_ext = {1'b0, mag_ff};
   end

   always_comb begin
      state_in = state_ff;
      vbits_in = vbits_ff;
      last_in = last_ff;
      sign_in = sign_ff;
      exact_in = exact_ff;
      mv_in = mv_ff;
      mf_in = mf_ff;
      ev_in = ev_ff;
      ef_in = ef_ff;
      sh_in = sh_ff;
      cnt_in = cnt_ff;
      mag_in = mag_ff;
      nrm_in = nrm_ff;
      en_in = en_ff;
      l_in = l_ff;
      mul_start = 1'b0;
      div_cmd = '0;
      item = '0;
      item.exact = exact_ff;
      item.encoded = exact_ff ? (sign_ff ? -mag_ext : mag_ext) : '0;
      item.raw_bits = vbits_ff;
      item.last = last_ff;
      unique case (state_ff)
         alp_ds_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               vbits_in = req_tdata;
               last_in = req_tlast;
               sign_in = req_tdata[63] ^ factor_ff[63];
               mv_in = v_mant;
               ev_in = v_e;
               mf_in = f_mant;
               ef_in = f_e;
               mag_in = '0;
               exact_in = pre_ok && v_zero;
               if (!pre_ok || v_zero) begin
                  state_in = alp_ds_pkg::ST_DONE;
               end else begin
                  state_in = alp_ds_pkg::ST_NORM;
               end
            end
         end
         alp_ds_pkg::ST_NORM: begin
            if (mv_ff[MW-1] && mf_ff[MW-1]) begin
               mul_start = 1'b1;
               state_in = alp_ds_pkg::ST_MUL;
            end else begin
               if (!mv_ff[MW-1]) begin
                  mv_in = {mv_ff[MW-2:0], 1'b0};
                  ev_in = ev_ff - alp_ds_pkg::exp_type'(1);
               end
               if (!mf_ff[MW-1]) begin
                  mf_in = {mf_ff[MW-2:0], 1'b0};
                  ef_in = ef_ff - alp_ds_pkg::exp_type'(1);
               end
            end
         end
         alp_ds_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = alp_ds_pkg::ST_MRND;
            end
         end
         alp_ds_pkg::ST_MRND: begin
            if (!ep[alp_ds_pkg::EXP_W-1]) begin
               nrm_in = mp;
               en_in = ep;
               if (ep == alp_ds_pkg::exp_type'(0)) begin
                  mag_in = {1'b0, mp};
                  state_in = alp_ds_pkg::ST_NORM2;
               end else if (ep == alp_ds_pkg::exp_type'(1) && mp == alp_ds_pkg::MANT_ONE) begin
                  mag_in = alp_ds_pkg::MAG_TWO_53;
                  state_in = alp_ds_pkg::ST_NORM2;
               end else begin
                  exact_in = 1'b0;
                  state_in = alp_ds_pkg::ST_DONE;
               end
            end else if (neg_ep >= alp_ds_pkg::exp_type'(54)) begin
               exact_in = 1'b0;
               state_in = alp_ds_pkg::ST_DONE;
            end else begin
               sh_in = mp;
               cnt_in = neg_ep[alp_ds_pkg::CNT_W-1:0];
               state_in = alp_ds_pkg::ST_SHIFT;
            end
         end
         alp_ds_pkg::ST_SHIFT: begin
            if (cnt_ff == alp_ds_pkg::CNT_W'(1)) begin
               mag_in = shift_mag;
               nrm_in = shift_mag[MW-1:0];
               en_in = '0;
               state_in = alp_ds_pkg::ST_NORM2;
            end else begin
               sh_in = {1'b0, sh_ff[MW-1:1]};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         alp_ds_pkg::ST_NORM2: begin
            if (nrm_ff[MW-1]) begin
               div_cmd.start = 1'b1;
               div_cmd.pre_shift = !n_ge_d;
               div_cmd.keep = keep;
               l_in = lead;
               state_in = alp_ds_pkg::ST_DIV;
            end else begin
               nrm_in = {nrm_ff[MW-2:0], 1'b0};
               en_in = en_ff - alp_ds_pkg::exp_type'(1);
            end
         end
         alp_ds_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               exact_in = (quot == mv_ff) && (ed == ev_ff);
               state_in = alp_ds_pkg::ST_DONE;
            end
         end
         alp_ds_pkg::ST_DONE: begin
            if (acc_ready) begin
               item.valid = 1'b1;
               state_in = alp_ds_pkg::ST_IDLE;
            end
         end
         default: state_in = alp_ds_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alp_ds_pkg::ST_IDLE;
         factor_ff <= alp_ds_pkg::FACTOR_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            factor_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      vbits_ff <= vbits_in;
      last_ff <= last_in;
      sign_ff <= sign_in;
      exact_ff <= exact_in;
      mv_ff <= mv_in;
      mf_ff <= mf_in;
      ev_ff <= ev_in;
      ef_ff <= ef_in;
      sh_ff <= sh_in;
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      nrm_ff <= nrm_in;
      en_ff <= en_in;
      l_ff <= l_in;
   end

   assign req_tready = (state_ff == alp_ds_pkg::ST_IDLE);

   alp_ds_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mv_ff),
      .b       (mf_ff),
      .done    (mul_done),
      .product (product)
   );

   alp_ds_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .n     (nrm_ff),
      .d     (mf_ff),
      .rsp   (div_rsp),
      .quot  (quot)
   );

   alp_ds_acc #(
      .MAX_BLOCK_ITEMS (MAX_BLOCK_ITEMS)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .ready      (acc_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
